// ----- rtl/dpfc_pkg.sv -----
`default_nettype none

package dpfc_pkg;

    // Default width of the input value.
    localparam int unsigned DefaultValueBits = 24;

    // Width of the distinct factor count and of the minimum register.
    localparam int unsigned CountBits = 4;

    // Value of the minimum register after reset.
    localparam logic [CountBits-1:0] MinDistinctReset = 4'd3;

    // Microprogram address.
    localparam int unsigned UpcBits = 4;
    typedef logic [UpcBits-1:0] upc_t;

    // Microprogram step addresses.
    localparam upc_t StepIdle       = 4'd0;
    localparam upc_t StepTest       = 4'd1;
    localparam upc_t StepDiv        = 4'd2;
    localparam upc_t StepWait       = 4'd3;
    localparam upc_t StepCheck      = 4'd4;
    localparam upc_t StepHit        = 4'd5;
    localparam upc_t StepDivAgain   = 4'd6;
    localparam upc_t StepWaitAgain  = 4'd7;
    localparam upc_t StepCheckAgain = 4'd8;
    localparam upc_t StepStrip      = 4'd9;
    localparam upc_t StepNext       = 4'd10;
    localparam upc_t StepFinish     = 4'd11;

    // Jump conditions: the jump is taken when the condition holds,
    // otherwise the step counter advances by one.
    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,
        JC_ALWAYS   = 3'd1,
        JC_NO_START = 3'd2,
        JC_SQ_GT    = 3'd3,
        JC_DIV_BUSY = 3'd4,
        JC_REM_NZ   = 3'd5
    } jump_cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        jump_cond_t cond;
        upc_t       target;
        logic       load;
        logic       div_start;
        logic       cnt_inc;
        logic       r_from_quot;
        logic       step_d;
        logic       emit;
    } ctrl_word_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic sq_gt_rem;
        logic div_busy;
        logic rem_nz;
    } status_t;

    // Microprogram store.
    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t cw;
        cw = '0;
        cw.cond = JC_NEXT;
        cw.target = StepIdle;
        unique case (addr)
            // Wait for an item; load it when it arrives.
            StepIdle:
            begin
                cw.load = 1'b1;
                cw.cond = JC_NO_START;
                cw.target = StepIdle;
            end
            // Stop once the divisor squared exceeds the remainder.
            StepTest:
            begin
                cw.cond = JC_SQ_GT;
                cw.target = StepFinish;
            end
            StepDiv:
            begin
                cw.div_start = 1'b1;
            end
            StepWait:
            begin
                cw.cond = JC_DIV_BUSY;
                cw.target = StepWait;
            end
            // No factor at this divisor: move on.
            StepCheck:
            begin
                cw.cond = JC_REM_NZ;
                cw.target = StepNext;
            end
            // New distinct factor: count it and take the quotient.
            StepHit:
            begin
                cw.cnt_inc = 1'b1;
                cw.r_from_quot = 1'b1;
            end
            StepDivAgain:
            begin
                cw.div_start = 1'b1;
            end
            StepWaitAgain:
            begin
                cw.cond = JC_DIV_BUSY;
                cw.target = StepWaitAgain;
            end
            StepCheckAgain:
            begin
                cw.cond = JC_REM_NZ;
                cw.target = StepNext;
            end
            // Same factor again: strip it and retry.
            StepStrip:
            begin
                cw.r_from_quot = 1'b1;
                cw.cond = JC_ALWAYS;
                cw.target = StepDivAgain;
            end
            StepNext:
            begin
                cw.step_d = 1'b1;
                cw.cond = JC_ALWAYS;
                cw.target = StepTest;
            end
            StepFinish:
            begin
                cw.emit = 1'b1;
                cw.cond = JC_ALWAYS;
                cw.target = StepIdle;
            end
            default:
            begin
                cw.cond = JC_ALWAYS;
                cw.target = StepIdle;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dpfc_divider.sv -----
`default_nettype none

module dpfc_divider #(
    parameter int unsigned VALUE_BITS = dpfc_pkg::DefaultValueBits,
    parameter int unsigned DIV_BITS   = (dpfc_pkg::DefaultValueBits + 1) / 2 + 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [DIV_BITS-1:0]   divisor,
    output logic                       busy,
    output logic [VALUE_BITS-1:0]      quotient,
    output logic [DIV_BITS-1:0]        rem_out
);

    localparam int unsigned IterBits = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] quot_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [IterBits-1:0]   iter_reg;
    logic                  busy_reg;

    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;
    logic                  fits;

    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, quot_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= IterBits'(VALUE_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (iter_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                iter_reg <= iter_reg - 1'b1;
            end
        end
    end

    // Quotient and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[VALUE_BITS-2:0], fits};
            rem_reg  <= fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;
    assign rem_out  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/dpfc_datapath.sv -----
`default_nettype none

module dpfc_datapath #(
    parameter int unsigned VALUE_BITS = dpfc_pkg::DefaultValueBits
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dpfc_pkg::ctrl_word_t               ctrl,
    input  wire logic                               start,
    input  wire logic [VALUE_BITS-1:0]              value,
    input  wire logic                               min_distinct_we,
    input  wire logic [dpfc_pkg::CountBits-1:0]     min_distinct,
    output dpfc_pkg::status_t                       status,
    output logic                                    done,
    output logic [dpfc_pkg::CountBits-1:0]          distinct_count,
    output logic                                    meets_minimum
);

    localparam int unsigned DivBits = (VALUE_BITS + 1) / 2 + 1;
    localparam int unsigned SqBits  = 2 * DivBits;
    localparam int unsigned CntBits = dpfc_pkg::CountBits;

    logic [VALUE_BITS-1:0] r_reg;
    logic [DivBits-1:0]    d_reg;
    logic [SqBits-1:0]     sq_reg;
    logic [CntBits-1:0]    cnt_reg;
    logic [CntBits-1:0]    min_reg;
    logic                  done_reg;
    logic [CntBits-1:0]    count_out_reg;
    logic                  meets_reg;

    logic                  div_busy;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DivBits-1:0]    div_rem;
    logic [CntBits-1:0]    final_count;
    logic                  load_item;

    dpfc_divider #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DivBits)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (r_reg),
        .divisor  (d_reg),
        .busy     (div_busy),
        .quotient (div_quot),
        .rem_out  (div_rem)
    );

    // Status back to the sequencer, and the count including a leftover prime.
    always_comb
    begin
        load_item        = ctrl.load && start;
        status.sq_gt_rem = (sq_reg > {{(SqBits - VALUE_BITS){1'b0}}, r_reg});
        status.div_busy  = div_busy;
        status.rem_nz    = |div_rem;
        final_count      = cnt_reg + {{(CntBits - 1){1'b0}}, (r_reg > VALUE_BITS'(1))};
    end

    // Working registers of the factor search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg   <= '0;
            d_reg   <= DivBits'(2);
            sq_reg  <= SqBits'(4);
            cnt_reg <= '0;
        end
        else
        begin
            if (load_item)
            begin
                r_reg   <= value;
                d_reg   <= DivBits'(2);
                sq_reg  <= SqBits'(4);
                cnt_reg <= '0;
            end
            else
            begin
                if (ctrl.r_from_quot)
                begin
                    r_reg <= div_quot;
                end
                if (ctrl.cnt_inc)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                // (d+1)^2 = d^2 + 2d + 1
                if (ctrl.step_d)
                begin
                    d_reg  <= d_reg + 1'b1;
                    sq_reg <= sq_reg + {{(SqBits - DivBits - 1){1'b0}}, d_reg, 1'b1};
                end
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= dpfc_pkg::MinDistinctReset;
        end
        else if (min_distinct_we)
        begin
            min_reg <= min_distinct;
        end
    end

    // Result register: one-cycle strobe with its fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            count_out_reg <= '0;
            meets_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
            if (ctrl.emit)
            begin
                count_out_reg <= final_count;
                meets_reg     <= (final_count >= min_reg);
            end
        end
    end

    assign done           = done_reg;
    assign distinct_count = count_out_reg;
    assign meets_minimum  = meets_reg;

    // A division start always makes the divider busy in the next cycle.
    a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |=> div_busy)
        else $error("divider did not start");

    // The divisor never reaches one or zero while searching.
    a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |-> (d_reg >= DivBits'(2)))
        else $error("trial divisor below two");

endmodule

`default_nettype wire

// ----- rtl/dpfc_sequencer.sv -----
`default_nettype none

module dpfc_sequencer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire dpfc_pkg::status_t    status,
    output dpfc_pkg::ctrl_word_t      ctrl,
    output logic                      busy
);

    dpfc_pkg::upc_t upc_reg;
    dpfc_pkg::upc_t upc_next;
    logic           take_jump;

    // Fetch the control word and resolve the jump condition.
    always_comb
    begin
        ctrl = dpfc_pkg::ucode_rom(upc_reg);
        unique case (ctrl.cond)
            dpfc_pkg::JC_NEXT:     take_jump = 1'b0;
            dpfc_pkg::JC_ALWAYS:   take_jump = 1'b1;
            dpfc_pkg::JC_NO_START: take_jump = !start;
            dpfc_pkg::JC_SQ_GT:    take_jump = status.sq_gt_rem;
            dpfc_pkg::JC_DIV_BUSY: take_jump = status.div_busy;
            dpfc_pkg::JC_REM_NZ:   take_jump = status.rem_nz;
            default:               take_jump = 1'b1;
        endcase
        upc_next = take_jump ? ctrl.target : upc_reg + 1'b1;
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= dpfc_pkg::StepIdle;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign busy = (upc_reg != dpfc_pkg::StepIdle);

    // An accepted item always leaves the idle step.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but sequencer stayed idle");

endmodule

`default_nettype wire

// ----- rtl/distinct_prime_factor_counter_top.sv -----
`default_nettype none

// Distinct prime factor counter.
// Give an item by driving value with start high while busy is low; it is taken
// at that clock edge. The block counts the distinct prime factors of value by
// trial division, trying divisors 2, 3, 4, ... until the divisor squared exceeds
// what is left of the value; a leftover above one counts as one more factor.
// Values 0 and 1 give a count of 0.
// The result appears on distinct_count and meets_minimum, marked by done for exactly
// one cycle. meets_minimum is set when the count is at least min_distinct.
// The user must write min_distinct through min_distinct_we only while the block is idle,
// which the block itself does not enforce. A microprogram steps a bit-serial divider.
// The worst case at 24 bits is about 4096 trial divisors. One item is in work at a
// time; busy falls in the cycle done rises, so the next item may be taken while the
// result is shown. The receiver cannot stall; each result is shown once. Reset
// returns the block to idle with min_distinct at 3.
module distinct_prime_factor_counter_top #(
    parameter int unsigned VALUE_BITS = dpfc_pkg::DefaultValueBits
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [VALUE_BITS-1:0]           value,
    input  wire logic                            min_distinct_we,
    input  wire logic [dpfc_pkg::CountBits-1:0]  min_distinct,
    output logic                                 done,
    output logic [dpfc_pkg::CountBits-1:0]       distinct_count,
    output logic                                 meets_minimum
);

    dpfc_pkg::ctrl_word_t ctrl;
    dpfc_pkg::status_t    status;

    // Microprogram sequencer.
    dpfc_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    // Search datapath with the divider and result registers.
    dpfc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .start           (start),
        .value           (value),
        .min_distinct_we (min_distinct_we),
        .min_distinct    (min_distinct),
        .status          (status),
        .done            (done),
        .distinct_count  (distinct_count),
        .meets_minimum   (meets_minimum)
    );

    // A result only follows a cycle of work.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without work");

    // Results are single-cycle strobes.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

    // An accepted item never produces its result in the very next cycle.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early");

endmodule

`default_nettype wire

// ----- verif/distinct_prime_factor_counter_top_tb.sv -----
`default_nettype none

module distinct_prime_factor_counter_top_tb;

    localparam int unsigned ValueBits = dpfc_pkg::DefaultValueBits;
    localparam longint unsigned ValueMax = (64'd1 << ValueBits) - 1;
    // Idle cycles allowed after the last result before the block is touched again.
    localparam int unsigned SettleCycles = 40;
    // Raw random values are only used when the search stays this short.
    localparam int unsigned RawTrialLimit = 700;
    localparam int unsigned ItemsPerPhase = 40;

    typedef logic [ValueBits-1:0] value_t;
    typedef logic [dpfc_pkg::CountBits-1:0] count_t;

    typedef struct {
        count_t distinct_count;
        logic   meets_minimum;
    } factor_result_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    value_t value;
    logic   min_distinct_we;
    count_t min_distinct;
    logic   done;
    count_t distinct_count;
    logic   meets_minimum;

    // Shadow of the minimum register and the results still owed by the block.
    count_t         min_distinct_shadow;
    factor_result_t pending_factor_results[$];
    int unsigned    items_sent;
    int unsigned    results_checked;
    int unsigned    mismatches;
    logic [15:0]    counts_seen;
    logic [15:0]    minimums_used;

    distinct_prime_factor_counter_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .value          (value),
        .min_distinct_we(min_distinct_we),
        .min_distinct   (min_distinct),
        .done           (done),
        .distinct_count (distinct_count),
        .meets_minimum  (meets_minimum)
    );

    always #1 clk = ~clk;

    // Trial division: strip each divisor fully, stop once its square passes the
    // remainder, and count a leftover above one as a final factor.
    function automatic count_t count_distinct_factors(input value_t v,
                                                      output int unsigned trials);
        longint unsigned rem;
        longint unsigned divisor;
        int unsigned     tally;
        rem = 64'(v);
        divisor = 2;
        tally = 0;
        while (divisor * divisor <= rem)
        begin
            if (rem % divisor == 0)
            begin
                tally++;
                while (rem % divisor == 0)
                    rem = rem / divisor;
            end
            divisor++;
        end
        if (rem > 1)
            tally++;
        trials = 32'(divisor);
        return count_t'(tally);
    endfunction

    // Smooth values: now and then a byte, else a modest cofactor times many small
    // divisors, keeping the search short while still reaching the top bits of the value.
    function automatic value_t make_smooth_value();
        longint unsigned v;
        longint unsigned p;
        if ($urandom_range(7, 0) == 0)
            return value_t'($urandom_range(255, 0));
        if ($urandom_range(3, 0) == 0)
            v = 64'($urandom_range(16383, 1));
        else
            v = 64'($urandom_range(64, 1));
        for (int i = 0; i < 24; i++)
        begin
            p = 64'($urandom_range(97, 2));
            if (v * p <= ValueMax)
                v = v * p;
        end
        return value_t'(v);
    endfunction

    // Mostly smooth values, now and then a raw random word whose search is short.
    function automatic value_t next_random_value();
        value_t      v;
        int unsigned trials;
        if ($urandom_range(11, 0) == 0)
        begin
            for (int tries = 0; tries < 8; tries++)
            begin
                v = value_t'($urandom);
                void'(count_distinct_factors(v, trials));
                if (trials <= RawTrialLimit)
                    return v;
            end
        end
        return make_smooth_value();
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input value_t v);
        logic           taken;
        int unsigned    trials;
        factor_result_t exp_result;
        start <= 1'b1;
        value <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        exp_result.distinct_count = count_distinct_factors(v, trials);
        exp_result.meets_minimum = (exp_result.distinct_count >= min_distinct_shadow);
        pending_factor_results.push_back(exp_result);
        items_sent++;
    endtask

    task automatic idle_for(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every owed result has arrived and the block has settled.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_factor_results.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_min_distinct(input count_t m);
        wait_results_drained();
        min_distinct_we <= 1'b1;
        min_distinct <= m;
        @(posedge clk);
        min_distinct_we <= 1'b0;
        min_distinct_shadow = m;
        minimums_used[m] = 1'b1;
    endtask

    // Check each result against the oldest outstanding item.
    always @(negedge clk)
    begin
        factor_result_t exp_result;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_factor_results.size() == 0)
            begin
                $error("distinct_count %0d arrived with no item outstanding",
                       distinct_count);
                mismatches++;
            end
            else
            begin
                exp_result = pending_factor_results.pop_front();
                results_checked++;
                counts_seen[exp_result.distinct_count] = 1'b1;
                if (distinct_count !== exp_result.distinct_count)
                begin
                    $error("distinct_count: expected %0d, actual %0d",
                           exp_result.distinct_count, distinct_count);
                    mismatches++;
                end
                if (meets_minimum !== exp_result.meets_minimum)
                begin
                    $error("meets_minimum: expected %0d, actual %0d",
                           exp_result.meets_minimum, meets_minimum);
                    mismatches++;
                end
            end
        end
    end

    // Default minimum after reset, with zero, one, field extremes and the
    // largest prime that fits, which is the longest search of all.
    task automatic test_reset_minimum_and_extremes();
        minimums_used[dpfc_pkg::MinDistinctReset] = 1'b1;
        send_item(value_t'(0));
        send_item(value_t'(1));
        send_item(value_t'(2));
        send_item(value_t'(3));
        send_item(value_t'(4));
        send_item(value_t'(30));
        send_item(value_t'(6));
        send_item(value_t'(ValueMax));
        send_item(value_t'(24'h800000));
        send_item(value_t'(9699690));
        send_item(value_t'(16777213));
        wait_results_drained();
    endtask

    // A minimum of zero sets the flag even for values with no factors.
    task automatic test_minimum_zero();
        write_min_distinct(count_t'(0));
        send_item(value_t'(0));
        send_item(value_t'(1));
        send_item(value_t'(2));
        wait_results_drained();
    endtask

    // Minimums above eight can never be met; eight is met by the product of
    // the first eight primes.
    task automatic test_minimum_high();
        write_min_distinct(count_t'(15));
        send_item(value_t'(9699690));
        send_item(value_t'(0));
        write_min_distinct(count_t'(9));
        send_item(value_t'(9699690));
        write_min_distinct(count_t'(8));
        send_item(value_t'(9699690));
        send_item(value_t'(510510));
        wait_results_drained();
    endtask

    // Random items with the sender idling at the given rate; halfway through
    // the first phase the sender waits for every result before going on.
    task automatic test_random_items(input count_t m, input int unsigned idle_pct,
                                     input logic drain_midway);
        write_min_distinct(m);
        for (int i = 0; i < ItemsPerPhase; i++)
        begin
            if (drain_midway && i == ItemsPerPhase / 2)
                wait_results_drained();
            if ($urandom_range(99, 0) < idle_pct)
                idle_for($urandom_range(60, 1));
            send_item(next_random_value());
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        value <= '0;
        min_distinct_we <= 1'b0;
        min_distinct <= '0;
        min_distinct_shadow = dpfc_pkg::MinDistinctReset;
        items_sent = 0;
        results_checked = 0;
        mismatches = 0;
        counts_seen = '0;
        minimums_used = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_minimum_and_extremes();
        test_minimum_zero();
        test_minimum_high();
        test_random_items(count_t'($urandom_range(15, 0)), 32, 1'b1);
        test_random_items(count_t'($urandom_range(8, 0)), 51, 1'b0);
        test_random_items(count_t'($urandom_range(8, 1)), 0, 1'b0);

        $display("Checked %0d results from %0d items; factor counts seen %b.",
                 results_checked, items_sent, counts_seen);
        $display("Minimum settings used %b, sender gaps at 32, 51 and 0 percent.",
                 minimums_used);
        if (mismatches == 0)
            $display("distinct_prime_factor_counter_top verification clean");
        else
            $display("distinct_prime_factor_counter_top verification failed");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #100000000;
        $display("distinct_prime_factor_counter_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
